FILE: rtl/core/kmdh_pkg.sv
// Shared definitions for the key matrix scanner and report builder.
// Holds matrix sizes, key positions, the HID usage tables and the transfer types.
// No dependencies; every other file of the block refers to this package.
package kmdh_pkg;

  localparam int COLUMNS      = 8;
  localparam int ROWS         = 6;
  localparam int SAMPLE_COUNT = 2;
  localparam int REPORT_SLOTS = 6;
  localparam int OUT_SLOTS    = 6;

  localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SMP_W       = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int STORE_DEPTH = COLUMNS * SAMPLE_COUNT;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SLOT_W      = $clog2(REPORT_SLOTS + 1);
  localparam int LAYER_W     = 3;

  localparam int SHIFT_COL  = 5;
  localparam int SHIFT_ROW  = 0;
  localparam int CURSOR_COL = 1;
  localparam int JOY_COL    = 0;
  localparam int STICK_ROW  = 5;
  localparam int FIRE_COL   = 7;
  localparam int UP_COL     = 5;
  localparam int DOWN_COL   = 3;
  localparam int LEFT_COL   = 6;
  localparam int RIGHT_COL  = 4;

  localparam logic [LAYER_W-1:0] LAYER_MENU = 3'd4;
  localparam logic [1:0]         MOD_SHIFT  = 2'd2;
  localparam logic [7:0]         KC_ROLLOVER = 8'h01;
  localparam logic [7:0]         KC_ESCAPE   = 8'h29;

  localparam logic [7:0] ROM_BASE [8][5] = '{
    '{8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22},
    '{8'h14, 8'h1A, 8'h08, 8'h15, 8'h17},
    '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0A},
    '{8'h27, 8'h26, 8'h25, 8'h24, 8'h23},
    '{8'h13, 8'h12, 8'h0C, 8'h18, 8'h1C},
    '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19},
    '{8'h28, 8'h0F, 8'h0E, 8'h0D, 8'h0B},
    '{8'h2C, 8'hE6, 8'h10, 8'h11, 8'h05}
  };

  localparam logic [7:0] ROM_ROW5 [6][8] = '{
    '{8'h43, 8'h42, 8'h3A, 8'h51, 8'h4F, 8'h52, 8'h50, 8'h27},
    '{8'h00, 8'h00, 8'h3A, 8'h51, 8'h4F, 8'h52, 8'h50, 8'h28},
    '{8'h43, 8'h42, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h3A, 8'h51, 8'h4F, 8'h52, 8'h50, 8'h28},
    '{8'h00, 8'h00, 8'h29, 8'h51, 8'h4F, 8'h52, 8'h50, 8'h29}
  };

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [ROWS-1:0]     data;
  } smp_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [ROWS-1:0]  data;
  } deb_wr_t;

  typedef struct packed {
    logic [2:0]                next_column;
    logic [4:0]                joystick_bits;
    logic                      report_valid;
    logic [1:0]                modifier;
    logic [OUT_SLOTS-1:0][7:0] keycode;
  } result_t;

  function automatic logic [7:0] usage(input logic [LAYER_W-1:0] layer,
                                       input logic [COL_W-1:0]   col,
                                       input logic [ROW_W-1:0]   row);
    logic [7:0] kc;
    kc = 8'h00;
    if ((32'(layer) <= 5) && (32'(col) <= 7) && (32'(row) <= 5)) begin
      if (32'(row) == 5) begin
        kc = ROM_ROW5[3'(layer)][3'(col)];
      end else if ((32'(layer) == 5) && (32'(col) == 6) && (32'(row) == 0)) begin
        kc = KC_ESCAPE;
      end else begin
        kc = ROM_BASE[3'(col)][3'(row)];
      end
    end
    return kc;
  endfunction

endpackage

FILE: rtl/core/key_matrix_debounce_hid_report.sv
// Key matrix scanner with debounce and HID keyboard report builder, top level.
// Instantiates kmdh_store and kmdh_seq and holds the result register.
// Depends on kmdh_pkg.
//
// The input channel carries one request per transfer: req_type_i low stores
// row_bits_i as a scan sample of the column being driven, high builds a report.
// Every request gives exactly one result on the output channel; next_column_o
// says which column to drive for the following sample. Both channels transfer
// when valid is high and stall is low.
// A scan runs from acceptance to a loaded result: one store write, one read per
// stored sample of the following column through the agreement logic, the
// debounce update and the hand-over of the result. A report takes a step for
// the mode keys and layer, the walk over all 48 key positions at one position
// per cycle through the usage table, and the hand-over.
// One request is in flight at a time; in_stall_o is high while it is worked on.
// After a result is loaded the block returns to idle, and only then is a new
// request taken. If the receiver stalls, the result holds and a finished request
// waits for it. Reset clears the sample store, debounced keys, column and sample
// indices, cursor mode and menu_mode. The user writes the register with
// cfg_we_i only while idle; the block itself does not enforce it.
module key_matrix_debounce_hid_report (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [5:0] row_bits_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] next_column_o,
  output logic [4:0] joystick_bits_o,
  output logic       report_valid_o,
  output logic [1:0] modifier_o,
  output logic [7:0] keycode_0_o,
  output logic [7:0] keycode_1_o,
  output logic [7:0] keycode_2_o,
  output logic [7:0] keycode_3_o,
  output logic [7:0] keycode_4_o,
  output logic [7:0] keycode_5_o
);

  logic                          menu_q, menu_d;
  logic                          out_valid_q, out_valid_d;
  kmdh_pkg::result_t             res_q, res_d;
  kmdh_pkg::result_t             seq_res;
  kmdh_pkg::smp_wr_t             smp_wr;
  kmdh_pkg::deb_wr_t             deb_wr;
  logic [kmdh_pkg::STORE_AW-1:0] smp_raddr;
  logic [kmdh_pkg::ROWS-1:0]     smp_rdata;
  logic [kmdh_pkg::COL_W-1:0]    deb_raddr;
  logic [kmdh_pkg::ROWS-1:0]     deb_rdata;
  logic [kmdh_pkg::COLUMNS-1:0]  stick;
  logic                          shift;
  logic                          busy;
  logic                          done;
  logic                          take;
  logic                          start;

  assign start      = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign take       = done && (!out_valid_q || !out_stall_i);

  kmdh_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_wr_i    (smp_wr),
    .smp_raddr_i (smp_raddr),
    .smp_rdata_o (smp_rdata),
    .deb_wr_i    (deb_wr),
    .deb_raddr_i (deb_raddr),
    .deb_rdata_o (deb_rdata),
    .stick_o     (stick),
    .shift_o     (shift)
  );

  kmdh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .row_bits_i  (row_bits_i),
    .menu_mode_i (menu_q),
    .take_i      (take),
    .busy_o      (busy),
    .done_o      (done),
    .result_o    (seq_res),
    .smp_wr_o    (smp_wr),
    .smp_raddr_o (smp_raddr),
    .smp_rdata_i (smp_rdata),
    .deb_wr_o    (deb_wr),
    .deb_raddr_o (deb_raddr),
    .deb_rdata_i (deb_rdata),
    .stick_i     (stick),
    .shift_i     (shift)
  );

  always_comb begin
    menu_d      = cfg_we_i ? cfg_wdata_i : menu_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (take) begin
      out_valid_d = 1'b1;
      res_d       = seq_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      menu_q      <= menu_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign next_column_o   = res_q.next_column;
  assign joystick_bits_o = res_q.joystick_bits;
  assign report_valid_o  = res_q.report_valid;
  assign modifier_o      = res_q.modifier;
  assign keycode_0_o     = res_q.keycode[0];
  assign keycode_1_o     = res_q.keycode[1];
  assign keycode_2_o     = res_q.keycode[2];
  assign keycode_3_o     = res_q.keycode[3];
  assign keycode_4_o     = res_q.keycode[4];
  assign keycode_5_o     = res_q.keycode[5];

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("no request in flight after a transfer on the input channel");

  a_scan_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !report_valid_o) |->
      (modifier_o == 2'd0 && keycode_0_o == 8'h00 && keycode_5_o == 8'h00))
    else $error("scan result carries report data");

  a_rollover_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && report_valid_o && keycode_0_o == kmdh_pkg::KC_ROLLOVER) |->
      (keycode_1_o == kmdh_pkg::KC_ROLLOVER && keycode_5_o == kmdh_pkg::KC_ROLLOVER))
    else $error("rollover not marked in every slot");

  a_menu_stick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && menu_q) |=> (joystick_bits_o == 5'd0))
    else $error("joystick bits given in menu mode");

endmodule

FILE: rtl/core/kmdh_store.sv
// Sample store and debounced key state of the matrix, all cleared by reset.
// One write and one read port each; the stick row and shift key leave as fixed taps.
// Depends on kmdh_pkg.
module kmdh_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kmdh_pkg::smp_wr_t              smp_wr_i,
  input  logic [kmdh_pkg::STORE_AW-1:0]  smp_raddr_i,
  output logic [kmdh_pkg::ROWS-1:0]      smp_rdata_o,
  input  kmdh_pkg::deb_wr_t              deb_wr_i,
  input  logic [kmdh_pkg::COL_W-1:0]     deb_raddr_i,
  output logic [kmdh_pkg::ROWS-1:0]      deb_rdata_o,
  output logic [kmdh_pkg::COLUMNS-1:0]   stick_o,
  output logic                           shift_o
);

  logic [kmdh_pkg::ROWS-1:0] smp_q [kmdh_pkg::STORE_DEPTH];
  logic [kmdh_pkg::ROWS-1:0] deb_q [kmdh_pkg::COLUMNS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmdh_pkg::STORE_DEPTH; i++) begin
        smp_q[i] <= '0;
      end
    end else if (smp_wr_i.en) begin
      smp_q[smp_wr_i.addr] <= smp_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmdh_pkg::COLUMNS; i++) begin
        deb_q[i] <= '0;
      end
    end else if (deb_wr_i.en) begin
      deb_q[deb_wr_i.addr] <= deb_wr_i.data;
    end
  end

  assign smp_rdata_o = smp_q[smp_raddr_i];
  assign deb_rdata_o = deb_q[deb_raddr_i];
  assign shift_o     = deb_q[kmdh_pkg::SHIFT_COL][kmdh_pkg::SHIFT_ROW];

  always_comb begin
    for (int c = 0; c < kmdh_pkg::COLUMNS; c++) begin
      stick_o[c] = deb_q[c][kmdh_pkg::STICK_ROW];
    end
  end

endmodule

FILE: rtl/core/kmdh_seq.sv
// Sequencer of the block: runs a scan through the store one sample per cycle and
// walks a report over every key position one per cycle through the usage table.
// Depends on kmdh_pkg; drives the ports of kmdh_store.
module kmdh_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          req_type_i,
  input  logic [5:0]                    row_bits_i,
  input  logic                          menu_mode_i,
  input  logic                          take_i,
  output logic                          busy_o,
  output logic                          done_o,
  output kmdh_pkg::result_t             result_o,
  output kmdh_pkg::smp_wr_t             smp_wr_o,
  output logic [kmdh_pkg::STORE_AW-1:0] smp_raddr_o,
  input  logic [kmdh_pkg::ROWS-1:0]     smp_rdata_i,
  output kmdh_pkg::deb_wr_t             deb_wr_o,
  output logic [kmdh_pkg::COL_W-1:0]    deb_raddr_o,
  input  logic [kmdh_pkg::ROWS-1:0]     deb_rdata_i,
  input  logic [kmdh_pkg::COLUMNS-1:0]  stick_i,
  input  logic                          shift_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_WR  = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_UPD = 3'd3;
  localparam logic [2:0] S_REP_MODE = 3'd4;
  localparam logic [2:0] S_REP_WALK = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  localparam logic [kmdh_pkg::COL_W-1:0] LAST_COL =
    kmdh_pkg::COL_W'(kmdh_pkg::COLUMNS - 1);
  localparam logic [kmdh_pkg::ROW_W-1:0] LAST_ROW =
    kmdh_pkg::ROW_W'(kmdh_pkg::ROWS - 1);
  localparam logic [kmdh_pkg::SMP_W-1:0] LAST_SMP =
    kmdh_pkg::SMP_W'(kmdh_pkg::SAMPLE_COUNT - 1);
  localparam logic [kmdh_pkg::SLOT_W-1:0] SLOTS_FULL =
    kmdh_pkg::SLOT_W'(kmdh_pkg::REPORT_SLOTS);

  logic [2:0]                          state_q, state_d;
  logic                                rep_q, rep_d;
  logic [kmdh_pkg::ROWS-1:0]           row_q, row_d;
  logic [kmdh_pkg::COL_W-1:0]          col_q, col_d;
  logic [kmdh_pkg::SMP_W-1:0]          smp_q, smp_d;
  logic [kmdh_pkg::SMP_W-1:0]          sit_q, sit_d;
  logic [kmdh_pkg::ROWS-1:0]           om_q, om_d;
  logic [kmdh_pkg::ROWS-1:0]           am_q, am_d;
  logic                                jm_q, jm_d;
  logic                                shift_q, shift_d;
  logic [kmdh_pkg::LAYER_W-1:0]        layer_q, layer_d;
  logic [kmdh_pkg::COL_W-1:0]          wc_q, wc_d;
  logic [kmdh_pkg::ROW_W-1:0]          wr_q, wr_d;
  logic [kmdh_pkg::SLOT_W-1:0]         ki_q, ki_d;
  logic                                ovf_q, ovf_d;
  logic [7:0]                          slots_q [kmdh_pkg::REPORT_SLOTS];
  logic [7:0]                          slots_d [kmdh_pkg::REPORT_SLOTS];
  logic [7:0]                          kc;
  logic                                jm_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      smp_q   <= '0;
      jm_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      smp_q   <= smp_d;
      jm_q    <= jm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q   <= rep_d;
    row_q   <= row_d;
    sit_q   <= sit_d;
    om_q    <= om_d;
    am_q    <= am_d;
    shift_q <= shift_d;
    layer_q <= layer_d;
    wc_q    <= wc_d;
    wr_q    <= wr_d;
    ki_q    <= ki_d;
    ovf_q   <= ovf_d;
    slots_q <= slots_d;
  end

  assign kc = kmdh_pkg::usage(layer_q, wc_q, wr_q);

  always_comb begin
    jm_new = jm_q;
    if (shift_i) begin
      if (stick_i[kmdh_pkg::CURSOR_COL]) begin
        jm_new = 1'b0;
      end
      if (stick_i[kmdh_pkg::JOY_COL]) begin
        jm_new = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rep_d   = rep_q;
    row_d   = row_q;
    col_d   = col_q;
    smp_d   = smp_q;
    sit_d   = sit_q;
    om_d    = om_q;
    am_d    = am_q;
    jm_d    = jm_q;
    shift_d = shift_q;
    layer_d = layer_q;
    wc_d    = wc_q;
    wr_d    = wr_q;
    ki_d    = ki_q;
    ovf_d   = ovf_q;
    slots_d = slots_q;

    smp_wr_o.en   = 1'b0;
    smp_wr_o.addr = kmdh_pkg::STORE_AW'(32'(col_q) * kmdh_pkg::SAMPLE_COUNT + 32'(smp_q));
    smp_wr_o.data = row_q;
    smp_raddr_o   = kmdh_pkg::STORE_AW'(32'(col_q) * kmdh_pkg::SAMPLE_COUNT + 32'(sit_q));
    deb_raddr_o   = (state_q == S_SCAN_UPD) ? col_q : wc_q;
    deb_wr_o.en   = 1'b0;
    deb_wr_o.addr = col_q;
    deb_wr_o.data = (am_q | deb_rdata_i) & om_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rep_d   = req_type_i;
          row_d   = row_bits_i[kmdh_pkg::ROWS-1:0];
          state_d = req_type_i ? S_REP_MODE : S_SCAN_WR;
        end
      end
      S_SCAN_WR: begin
        smp_wr_o.en = 1'b1;
        if (col_q == LAST_COL) begin
          col_d = '0;
          smp_d = (smp_q == LAST_SMP) ? '0 : smp_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        sit_d   = '0;
        om_d    = '0;
        am_d    = '1;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        om_d  = om_q | smp_rdata_i;
        am_d  = am_q & smp_rdata_i;
        sit_d = sit_q + 1'b1;
        if (sit_q == LAST_SMP) begin
          state_d = S_SCAN_UPD;
        end
      end
      S_SCAN_UPD: begin
        deb_wr_o.en = 1'b1;
        state_d     = S_DONE;
      end
      S_REP_MODE: begin
        jm_d    = jm_new;
        shift_d = shift_i;
        layer_d = (menu_mode_i ? kmdh_pkg::LAYER_MENU : {1'b0, jm_new, 1'b0})
                  + {2'b00, shift_i};
        wc_d    = '0;
        wr_d    = '0;
        ki_d    = '0;
        ovf_d   = 1'b0;
        for (int i = 0; i < kmdh_pkg::REPORT_SLOTS; i++) begin
          slots_d[i] = 8'h00;
        end
        state_d = S_REP_WALK;
      end
      S_REP_WALK: begin
        if (deb_rdata_i[wr_q]) begin
          if (ki_q >= SLOTS_FULL) begin
            ovf_d = 1'b1;
          end else if (kc != 8'h00) begin
            slots_d[ki_q] = kc;
            ki_d          = ki_q + 1'b1;
          end
        end
        if (wr_q == LAST_ROW) begin
          wr_d = '0;
          wc_d = wc_q + 1'b1;
          if (wc_q == LAST_COL) begin
            state_d = S_DONE;
          end
        end else begin
          wr_d = wr_q + 1'b1;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    result_o.next_column  = 3'(col_q);
    result_o.report_valid = rep_q;
    result_o.modifier     = (rep_q && shift_q) ? kmdh_pkg::MOD_SHIFT : 2'd0;
    if (jm_q && !menu_mode_i) begin
      result_o.joystick_bits = {stick_i[kmdh_pkg::FIRE_COL], stick_i[kmdh_pkg::UP_COL],
                                stick_i[kmdh_pkg::DOWN_COL], stick_i[kmdh_pkg::LEFT_COL],
                                stick_i[kmdh_pkg::RIGHT_COL]};
    end else begin
      result_o.joystick_bits = 5'd0;
    end
    for (int i = 0; i < kmdh_pkg::OUT_SLOTS; i++) begin
      result_o.keycode[i] = 8'h00;
      if (rep_q && (i < kmdh_pkg::REPORT_SLOTS)) begin
        result_o.keycode[i] = ovf_q ? kmdh_pkg::KC_ROLLOVER : slots_q[i];
      end
    end
  end

endmodule
